### rtl/core/krl_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// krl_pkg
// Shared constants, codes and types of the keyed failure-rate limiter.
// ----------------------------------------------------------------------------
package krl_pkg;

    localparam int TABLE_ENTRIES = 1024;
    localparam int COUNT_BITS    = 16;
    localparam int CFG_BITS      = 16;
    localparam int KEY_BITS      = 96;
    localparam int TABLES        = 4;
    localparam int TAB_BITS      = 2;
    localparam int CELLS         = 16;
    localparam int CELL_BITS     = $clog2(CELLS);
    localparam int CELL_ROWS     = TABLE_ENTRIES / CELLS;
    localparam int ROW_BITS      = $clog2(CELL_ROWS);
    localparam int RAM_DEPTH     = TABLES * CELL_ROWS;
    localparam int RAM_ABITS     = TAB_BITS + ROW_BITS;
    localparam int LIVE_BITS     = $clog2(TABLE_ENTRIES + 1);

    localparam logic [COUNT_BITS-1:0] COUNT_TOP = '1;
    localparam logic [ROW_BITS-1:0]   ROW_LAST  = ROW_BITS'(CELL_ROWS - 1);
    localparam logic [RAM_ABITS-1:0]  ADDR_LAST = RAM_ABITS'(RAM_DEPTH - 1);

    localparam logic [CFG_BITS-1:0] LIM_REG_DEFAULT   = 16'd50;
    localparam logic [CFG_BITS-1:0] LIM_LOGIN_DEFAULT = 16'd5;
    localparam logic [CFG_BITS-1:0] LIM_MAC_DEFAULT   = 16'd15;

    // commands
    localparam logic [3:0] CMD_CHK_REG      = 4'd0;
    localparam logic [3:0] CMD_CHK_LOGIN    = 4'd1;
    localparam logic [3:0] CMD_CHK_CARD     = 4'd2;
    localparam logic [3:0] CMD_CANCEL_LOGIN = 4'd3;
    localparam logic [3:0] CMD_CANCEL_REG   = 4'd4;
    localparam logic [3:0] CMD_CANCEL_CARD  = 4'd5;
    localparam logic [3:0] CMD_LOGIN_OK     = 4'd6;
    localparam logic [3:0] CMD_REG_FAIL     = 4'd7;
    localparam logic [3:0] CMD_CARD_OK      = 4'd8;
    localparam logic [3:0] CMD_HOUR         = 4'd9;

    // tables
    localparam logic [TAB_BITS-1:0] TAB_REG   = 2'd0;
    localparam logic [TAB_BITS-1:0] TAB_LOGIN = 2'd1;
    localparam logic [TAB_BITS-1:0] TAB_CARD  = 2'd2;
    localparam logic [TAB_BITS-1:0] TAB_MAC   = 2'd3;

    // table operations
    localparam logic [2:0] OP_BUMP    = 3'd0;
    localparam logic [2:0] OP_DEC     = 3'd1;
    localparam logic [2:0] OP_DROPDEC = 3'd2;
    localparam logic [2:0] OP_REMOVE  = 3'd3;
    localparam logic [2:0] OP_REGFAIL = 3'd4;

    // configuration register indexes
    localparam logic [1:0] CFG_MAX_REG   = 2'd0;
    localparam logic [1:0] CFG_MAX_LOGIN = 2'd1;
    localparam logic [1:0] CFG_MAX_MAC   = 2'd2;

    typedef struct packed {
        logic [3:0]  command;
        logic [31:0] ip;
        logic [63:0] name_key;
        logic [63:0] mac_key;
        logic        mac_present;
        logic [4:0]  hour;
    } t_in;

    typedef struct packed {
        logic                 limited;
        logic                 table_full;
        logic [LIVE_BITS-1:0] login_entries;
        logic [LIVE_BITS-1:0] register_entries;
        logic [LIVE_BITS-1:0] mac_entries;
    } t_out;

    typedef struct packed {
        logic                  valid;
        logic [KEY_BITS-1:0]   key;
        logic [COUNT_BITS-1:0] count;
    } t_entry;

    // match / free token handed along the row of cells
    typedef struct packed {
        logic                  found;
        logic [CELL_BITS-1:0]  fcell;
        logic [COUNT_BITS-1:0] fcnt;
        logic                  free;
        logic [CELL_BITS-1:0]  rcell;
    } t_chain;

    typedef struct packed {
        logic                 en;
        logic                 all;
        logic [CELL_BITS-1:0] dst;
        logic [RAM_ABITS-1:0] addr;
        t_entry               data;
    } t_wr;

endpackage
`default_nettype wire

### rtl/core/keyed_failure_rate_limiter_top.sv
`timescale 1ns / 1ps
`default_nettype none
// Steps: start, a scan over all 64 rows, read lag, apply, response; login
//   commands touching the MAC table scan and apply once more before responding.
// One transaction at a time; input is taken only while idle.
// Hour change: clearing sweep over all 256 RAM addresses before the response.
// Reset: synchronous active-low; a clearing sweep runs first and no
//   input is taken until it ends. Configuration writes are taken out of reset.
// ----------------------------------------------------------------------------
// keyed_failure_rate_limiter_top
// Four keyed counter tables spread over a row of cells, scanned row by row.
// ----------------------------------------------------------------------------
module keyed_failure_rate_limiter_top (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    output logic                      o_in_ready,
    input  wire krl_pkg::t_in         i_in_data,
    output logic                      o_out_valid,
    input  wire logic                 i_out_ready,
    output krl_pkg::t_out             o_out_data,
    input  wire logic                 i_cfg_we,
    input  wire logic [1:0]           i_cfg_index,
    input  wire logic [15:0]          i_cfg_data
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_START = 3'd1;
    localparam logic [2:0] ST_SCAN  = 3'd2;
    localparam logic [2:0] ST_APPLY = 3'd3;
    localparam logic [2:0] ST_RESP  = 3'd4;
    localparam logic [2:0] ST_CLEAR = 3'd5;

    logic [2:0]                        r_state;
    krl_pkg::t_in                      r_in;
    logic                              r_pass;
    logic [2:0]                        r_op;
    logic [krl_pkg::TAB_BITS-1:0]      r_tab;
    logic [krl_pkg::KEY_BITS-1:0]      r_key;
    logic [krl_pkg::ROW_BITS-1:0]      r_row;
    logic                              r_issue;
    logic                              r_ev;
    logic [krl_pkg::ROW_BITS-1:0]      r_ev_row;
    logic                              r_found;
    logic [krl_pkg::CELL_BITS-1:0]     r_fcell;
    logic [krl_pkg::ROW_BITS-1:0]      r_frow;
    logic [krl_pkg::COUNT_BITS-1:0]    r_fcnt;
    logic                              r_free;
    logic [krl_pkg::CELL_BITS-1:0]     r_rcell;
    logic [krl_pkg::ROW_BITS-1:0]      r_rrow;
    logic                              r_lim;
    logic                              r_full;
    logic [krl_pkg::LIVE_BITS-1:0]     r_live [0:krl_pkg::TABLES-1];
    logic [krl_pkg::RAM_ABITS-1:0]     r_clr_addr;
    logic                              r_clr_resp;
    logic [4:0]                        r_hour;
    logic [krl_pkg::CFG_BITS-1:0]      r_max_reg;
    logic [krl_pkg::CFG_BITS-1:0]      r_max_login;
    logic [krl_pkg::CFG_BITS-1:0]      r_max_mac;
    logic                              r_ovalid;
    krl_pkg::t_out                     r_odata;

    krl_pkg::t_chain                   w_chain [0:krl_pkg::CELLS];
    krl_pkg::t_wr                      w_wr;
    logic [krl_pkg::RAM_ABITS-1:0]     w_raddr;

    // apply step
    logic                              a_wen;
    logic [krl_pkg::CELL_BITS-1:0]     a_cell;
    logic [krl_pkg::ROW_BITS-1:0]      a_row;
    logic                              a_valid;
    logic [krl_pkg::COUNT_BITS-1:0]    a_cnt;
    logic                              a_inc;
    logic                              a_dec;
    logic                              a_fail;

    // next pass / result decision
    logic                              np_go;
    logic [2:0]                        np_op;
    logic [krl_pkg::TAB_BITS-1:0]      np_tab;
    logic [krl_pkg::KEY_BITS-1:0]      np_key;
    logic                              np_resp;
    logic                              np_clear;
    logic                              np_lim;
    logic                              np_full;
    logic                              w_ipbad;

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_ovalid;
    assign o_out_data  = r_odata;
    assign w_raddr     = {r_tab, r_row};
    assign w_ipbad     = (r_in.ip == 32'd0) || (r_in.ip == 32'hFFFF_FFFF);

    assign w_chain[0] = '0;

    genvar g;
    generate
        for (g = 0; g < krl_pkg::CELLS; g++) begin : g_cell
            krl_cell u_cell (
                .i_clk      (i_clk),
                .i_cell_idx (krl_pkg::CELL_BITS'(g)),
                .i_raddr    (w_raddr),
                .i_wr       (w_wr),
                .i_key      (r_key),
                .i_chain    (w_chain[g]),
                .o_chain    (w_chain[g+1])
            );
        end
    endgenerate

    always_comb begin
        a_wen   = 1'b0;
        a_cell  = r_fcell;
        a_row   = r_frow;
        a_valid = 1'b1;
        a_cnt   = r_fcnt;
        a_inc   = 1'b0;
        a_dec   = 1'b0;
        a_fail  = 1'b0;
        case (r_op)
            krl_pkg::OP_BUMP: begin
                if (r_found) begin
                    a_wen = 1'b1;
                    if (r_fcnt != krl_pkg::COUNT_TOP) begin
                        a_cnt = r_fcnt + krl_pkg::COUNT_BITS'(1);
                    end
                end else if (r_free) begin
                    a_wen  = 1'b1;
                    a_cell = r_rcell;
                    a_row  = r_rrow;
                    a_cnt  = krl_pkg::COUNT_BITS'(1);
                    a_inc  = 1'b1;
                end else begin
                    a_fail = 1'b1;
                end
            end
            krl_pkg::OP_DEC, krl_pkg::OP_DROPDEC: begin
                if (r_found) begin
                    a_wen = 1'b1;
                    if (r_fcnt != '0) begin
                        a_cnt = r_fcnt - krl_pkg::COUNT_BITS'(1);
                    end
                    if ((r_op == krl_pkg::OP_DROPDEC) && (a_cnt == '0)) begin
                        a_valid = 1'b0;
                        a_dec   = 1'b1;
                    end
                end
            end
            krl_pkg::OP_REMOVE: begin
                if (r_found) begin
                    a_wen   = 1'b1;
                    a_valid = 1'b0;
                    a_dec   = 1'b1;
                end
            end
            krl_pkg::OP_REGFAIL: begin
                if (r_found) begin
                    a_wen = 1'b1;
                    if (r_fcnt <= krl_pkg::COUNT_BITS'(1)) begin
                        a_valid = 1'b0;
                        a_dec   = 1'b1;
                    end else begin
                        a_cnt = r_fcnt - krl_pkg::COUNT_BITS'(1);
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        w_wr = '0;
        if (r_state == ST_CLEAR) begin
            w_wr.en   = 1'b1;
            w_wr.all  = 1'b1;
            w_wr.addr = r_clr_addr;
        end else if ((r_state == ST_APPLY) && a_wen) begin
            w_wr.en         = 1'b1;
            w_wr.dst        = a_cell;
            w_wr.addr       = {r_tab, a_row};
            w_wr.data.valid = a_valid;
            w_wr.data.key   = r_key;
            w_wr.data.count = a_cnt;
        end
    end

    always_comb begin
        np_go    = 1'b0;
        np_op    = krl_pkg::OP_BUMP;
        np_tab   = krl_pkg::TAB_REG;
        np_key   = '0;
        np_resp  = 1'b0;
        np_clear = 1'b0;
        // flags start clear for each new transaction
        np_lim   = (r_state == ST_IDLE) ? 1'b0 : r_lim;
        np_full  = (r_state == ST_IDLE) ? 1'b0 : r_full;
        if (r_state == ST_START) begin
            case (r_in.command)
                krl_pkg::CMD_CHK_REG: begin
                    if (w_ipbad) begin
                        np_lim  = 1'b1;
                        np_resp = 1'b1;
                    end else begin
                        np_go  = 1'b1;
                        np_key = {64'd0, r_in.ip};
                    end
                end
                krl_pkg::CMD_CHK_LOGIN: begin
                    np_go  = 1'b1;
                    np_tab = krl_pkg::TAB_LOGIN;
                    np_key = {r_in.name_key, r_in.ip};
                end
                krl_pkg::CMD_CHK_CARD: begin
                    np_go  = 1'b1;
                    np_tab = krl_pkg::TAB_CARD;
                    np_key = {r_in.name_key, r_in.ip};
                end
                krl_pkg::CMD_CANCEL_LOGIN: begin
                    np_go  = 1'b1;
                    np_op  = krl_pkg::OP_DEC;
                    np_tab = krl_pkg::TAB_LOGIN;
                    np_key = {r_in.name_key, r_in.ip};
                end
                krl_pkg::CMD_CANCEL_REG: begin
                    if (w_ipbad) begin
                        np_resp = 1'b1;
                    end else begin
                        np_go  = 1'b1;
                        np_op  = krl_pkg::OP_DEC;
                        np_key = {64'd0, r_in.ip};
                    end
                end
                krl_pkg::CMD_CANCEL_CARD: begin
                    np_go  = 1'b1;
                    np_op  = krl_pkg::OP_DEC;
                    np_tab = krl_pkg::TAB_CARD;
                    np_key = {r_in.name_key, r_in.ip};
                end
                krl_pkg::CMD_LOGIN_OK: begin
                    np_go  = 1'b1;
                    np_op  = krl_pkg::OP_REMOVE;
                    np_tab = krl_pkg::TAB_LOGIN;
                    np_key = {r_in.name_key, r_in.ip};
                end
                krl_pkg::CMD_REG_FAIL: begin
                    np_go  = 1'b1;
                    np_op  = krl_pkg::OP_REGFAIL;
                    np_key = {64'd0, r_in.ip};
                end
                krl_pkg::CMD_CARD_OK: begin
                    np_go  = 1'b1;
                    np_op  = krl_pkg::OP_REMOVE;
                    np_tab = krl_pkg::TAB_CARD;
                    np_key = {r_in.name_key, r_in.ip};
                end
                krl_pkg::CMD_HOUR: begin
                    if (r_in.hour != r_hour) begin
                        np_clear = 1'b1;
                    end else begin
                        np_resp = 1'b1;
                    end
                end
                default: begin
                    np_resp = 1'b1;
                end
            endcase
        end else if (r_state == ST_APPLY) begin
            np_tab = krl_pkg::TAB_MAC;
            np_key = {r_in.mac_key, 32'd0};
            if (r_pass) begin
                // MAC pass: only the check command reports from it
                np_resp = 1'b1;
                if (r_op == krl_pkg::OP_BUMP) begin
                    np_lim  = a_fail || (a_cnt > r_max_mac);
                    np_full = a_fail;
                end
            end else begin
                case (r_in.command)
                    krl_pkg::CMD_CHK_REG: begin
                        np_lim  = a_fail || (a_cnt > r_max_reg);
                        np_full = a_fail;
                        np_resp = 1'b1;
                    end
                    krl_pkg::CMD_CHK_CARD: begin
                        np_lim  = a_fail || (a_cnt > r_max_login);
                        np_full = a_fail;
                        np_resp = 1'b1;
                    end
                    krl_pkg::CMD_CHK_LOGIN: begin
                        np_lim  = a_fail || (a_cnt > r_max_login);
                        np_full = a_fail;
                        if (!np_lim && r_in.mac_present) begin
                            np_go = 1'b1;
                        end else begin
                            np_resp = 1'b1;
                        end
                    end
                    krl_pkg::CMD_CANCEL_LOGIN, krl_pkg::CMD_LOGIN_OK: begin
                        if (r_in.mac_present) begin
                            np_go = 1'b1;
                            np_op = krl_pkg::OP_DROPDEC;
                        end else begin
                            np_resp = 1'b1;
                        end
                    end
                    default: begin
                        np_resp = 1'b1;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr_addr  <= '0;
            r_clr_resp  <= 1'b0;
            r_issue     <= 1'b0;
            r_ev        <= 1'b0;
            r_ovalid    <= 1'b0;
            r_hour      <= '0;
            r_max_reg   <= krl_pkg::LIM_REG_DEFAULT;
            r_max_login <= krl_pkg::LIM_LOGIN_DEFAULT;
            r_max_mac   <= krl_pkg::LIM_MAC_DEFAULT;
            for (int t = 0; t < krl_pkg::TABLES; t++) begin
                r_live[t] <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    krl_pkg::CFG_MAX_REG:   r_max_reg   <= i_cfg_data;
                    krl_pkg::CFG_MAX_LOGIN: r_max_login <= i_cfg_data;
                    krl_pkg::CFG_MAX_MAC:   r_max_mac   <= i_cfg_data;
                    default: begin
                    end
                endcase
            end

            if (r_ovalid && i_out_ready && (r_state != ST_RESP)) begin
                r_ovalid <= 1'b0;
            end

            r_lim  <= np_lim;
            r_full <= np_full;

            case (r_state)
                ST_IDLE: begin
                    if (i_in_valid) begin
                        r_in    <= i_in_data;
                        r_pass  <= 1'b0;
                        r_state <= ST_START;
                    end
                end
                ST_SCAN: begin
                    if (r_issue) begin
                        r_row <= r_row + krl_pkg::ROW_BITS'(1);
                        if (r_row == krl_pkg::ROW_LAST) begin
                            r_issue <= 1'b0;
                        end
                    end
                    r_ev     <= r_issue;
                    r_ev_row <= r_row;
                    if (r_ev) begin
                        if (w_chain[krl_pkg::CELLS].found && !r_found) begin
                            r_found <= 1'b1;
                            r_fcell <= w_chain[krl_pkg::CELLS].fcell;
                            r_fcnt  <= w_chain[krl_pkg::CELLS].fcnt;
                            r_frow  <= r_ev_row;
                        end
                        if (w_chain[krl_pkg::CELLS].free && !r_free) begin
                            r_free  <= 1'b1;
                            r_rcell <= w_chain[krl_pkg::CELLS].rcell;
                            r_rrow  <= r_ev_row;
                        end
                        if (r_ev_row == krl_pkg::ROW_LAST) begin
                            r_state <= ST_APPLY;
                        end
                    end
                end
                ST_APPLY: begin
                    r_pass <= 1'b1;
                    if (a_inc) begin
                        r_live[r_tab] <= r_live[r_tab] + krl_pkg::LIVE_BITS'(1);
                    end else if (a_dec) begin
                        r_live[r_tab] <= r_live[r_tab] - krl_pkg::LIVE_BITS'(1);
                    end
                end
                ST_RESP: begin
                    if (!r_ovalid || i_out_ready) begin
                        r_ovalid                 <= 1'b1;
                        r_odata.limited          <= r_lim;
                        r_odata.table_full       <= r_full;
                        r_odata.login_entries    <= r_live[krl_pkg::TAB_LOGIN];
                        r_odata.register_entries <= r_live[krl_pkg::TAB_REG];
                        r_odata.mac_entries      <= r_live[krl_pkg::TAB_MAC];
                        r_state                  <= ST_IDLE;
                    end
                end
                ST_CLEAR: begin
                    if (r_clr_addr == krl_pkg::ADDR_LAST) begin
                        r_clr_addr <= '0;
                        r_state    <= r_clr_resp ? ST_RESP : ST_IDLE;
                    end else begin
                        r_clr_addr <= r_clr_addr + krl_pkg::RAM_ABITS'(1);
                    end
                end
                default: begin
                end
            endcase

            // transitions out of start / apply
            if (np_go) begin
                r_op    <= np_op;
                r_tab   <= np_tab;
                r_key   <= np_key;
                r_row   <= '0;
                r_issue <= 1'b1;
                r_ev    <= 1'b0;
                r_found <= 1'b0;
                r_free  <= 1'b0;
                r_state <= ST_SCAN;
            end else if (np_resp) begin
                r_state <= ST_RESP;
            end else if (np_clear) begin
                r_hour     <= r_in.hour;
                r_clr_addr <= '0;
                r_clr_resp <= 1'b1;
                r_state    <= ST_CLEAR;
                for (int t = 0; t < krl_pkg::TABLES; t++) begin
                    r_live[t] <= '0;
                end
            end
        end
    end

endmodule
`default_nettype wire

### rtl/core/krl_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// krl_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module krl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [0:DEPTH-1];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

### rtl/core/krl_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// krl_cell
// One cell of the lookup row: holds a slice of every table, compares the
// row it reads with the key and merges its hit / free slot into the token.
// ----------------------------------------------------------------------------
module krl_cell (
    input  wire logic                            i_clk,
    input  wire logic [krl_pkg::CELL_BITS-1:0]   i_cell_idx,
    input  wire logic [krl_pkg::RAM_ABITS-1:0]   i_raddr,
    input  wire krl_pkg::t_wr                    i_wr,
    input  wire logic [krl_pkg::KEY_BITS-1:0]    i_key,
    input  wire krl_pkg::t_chain                 i_chain,
    output krl_pkg::t_chain                      o_chain
);

    krl_pkg::t_entry w_rdata;
    logic            w_we;
    logic            w_hit;

    assign w_we = i_wr.en && (i_wr.all || (i_wr.dst == i_cell_idx));

    krl_ram #(
        .WIDTH ($bits(krl_pkg::t_entry)),
        .DEPTH (krl_pkg::RAM_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (i_wr.addr),
        .i_wdata (i_wr.data),
        .i_raddr (i_raddr),
        .o_rdata (w_rdata)
    );

    assign w_hit = w_rdata.valid && (w_rdata.key == i_key);

    always_comb begin
        o_chain = i_chain;
        if (!i_chain.found && w_hit) begin
            o_chain.found = 1'b1;
            o_chain.fcell = i_cell_idx;
            o_chain.fcnt  = w_rdata.count;
        end
        if (!i_chain.free && !w_rdata.valid) begin
            o_chain.free  = 1'b1;
            o_chain.rcell = i_cell_idx;
        end
    end

endmodule
`default_nettype wire

### test/keyed_failure_rate_limiter_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keyed_failure_rate_limiter_top_tb
// Drives limiter commands through the valid/ready channels and compares every
// response with an in-bench model of the four keyed counter tables.
// ----------------------------------------------------------------------------
module keyed_failure_rate_limiter_top_tb;

    localparam int LIMIT_CYCLES = 10_000_000;
    localparam int SETTLE       = 400;
    localparam int HOLD_LONG    = 3000;

    logic          i_clk;
    logic          i_rst_n;
    logic          in_valid;
    logic          in_ready;
    krl_pkg::t_in  in_data;
    logic          out_valid;
    logic          out_ready;
    krl_pkg::t_out out_data;
    logic          cfg_we;
    logic [1:0]    cfg_index;
    logic [15:0]   cfg_data;

    keyed_failure_rate_limiter_top u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    // table model
    logic        slot_live [4][krl_pkg::TABLE_ENTRIES];
    logic [63:0] slot_name [4][krl_pkg::TABLE_ENTRIES];
    logic [31:0] slot_addr [4][krl_pkg::TABLE_ENTRIES];
    logic [15:0] slot_cnt  [4][krl_pkg::TABLE_ENTRIES];
    int          live_cnt  [4];
    logic [4:0]  cur_hour;
    logic [15:0] lim_reg, lim_login, lim_mac;

    krl_pkg::t_out pending_q [$];
    int          errors;
    int          cycles;
    bit          tx_quiet;
    int          hold_go, hold_seen, hold_left, rdy_gap;
    bit          rdy_calm;
    logic [31:0] ip_pool [8];
    logic [63:0] name_pool [6];
    logic [63:0] mac_pool [4];

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 80) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(30, 120);
    endfunction

    function automatic int find_slot(int t, logic [63:0] n, logic [31:0] a);
        for (int i = 0; i < krl_pkg::TABLE_ENTRIES; i++)
            if (slot_live[t][i] && slot_name[t][i] == n && slot_addr[t][i] == a) return i;
        return -1;
    endfunction

    task automatic count_up(input int t, input logic [63:0] n, input logic [31:0] a,
                            output bit ok, output logic [15:0] c);
        int i;
        i = find_slot(t, n, a);
        ok = 1'b1;
        if (i >= 0) begin
            if (slot_cnt[t][i] != krl_pkg::COUNT_TOP) slot_cnt[t][i]++;
            c = slot_cnt[t][i];
            return;
        end
        for (int j = 0; j < krl_pkg::TABLE_ENTRIES; j++) begin
            if (!slot_live[t][j]) begin
                slot_live[t][j] = 1'b1;
                slot_name[t][j] = n;
                slot_addr[t][j] = a;
                slot_cnt[t][j]  = 16'd1;
                live_cnt[t]++;
                c = 16'd1;
                return;
            end
        end
        ok = 1'b0;
        c  = '0;
    endtask

    task automatic drop_slot(input int t, input int i);
        if (i >= 0 && slot_live[t][i]) begin
            slot_live[t][i] = 1'b0;
            live_cnt[t]--;
        end
    endtask

    task automatic count_down(input int t, input logic [63:0] n, input logic [31:0] a,
                              input bit drop);
        int i;
        i = find_slot(t, n, a);
        if (i < 0) return;
        if (slot_cnt[t][i] != 0) slot_cnt[t][i]--;
        if (drop && slot_cnt[t][i] == 0) drop_slot(t, i);
    endtask

    task automatic clear_tables();
        for (int t = 0; t < 4; t++) begin
            for (int i = 0; i < krl_pkg::TABLE_ENTRIES; i++) slot_live[t][i] = 1'b0;
            live_cnt[t] = 0;
        end
    endtask

    task automatic predict_limit(input krl_pkg::t_in it, output krl_pkg::t_out r);
        bit          ok, ip_bad, lim, full;
        logic [15:0] c;
        int          i;
        ip_bad = (it.ip == '0) || (it.ip == '1);
        lim = 1'b0;
        full = 1'b0;
        case (it.command)
            krl_pkg::CMD_CHK_REG: begin
                if (ip_bad) lim = 1'b1;
                else begin
                    count_up(krl_pkg::TAB_REG, '0, it.ip, ok, c);
                    if (!ok) begin lim = 1'b1; full = 1'b1; end
                    else lim = c > lim_reg;
                end
            end
            krl_pkg::CMD_CHK_LOGIN: begin
                count_up(krl_pkg::TAB_LOGIN, it.name_key, it.ip, ok, c);
                if (!ok) begin
                    lim = 1'b1; full = 1'b1;
                end else begin
                    lim = c > lim_login;
                    if (!lim && it.mac_present) begin
                        count_up(krl_pkg::TAB_MAC, it.mac_key, '0, ok, c);
                        if (!ok) begin lim = 1'b1; full = 1'b1; end
                        else lim = c > lim_mac;
                    end
                end
            end
            krl_pkg::CMD_CHK_CARD: begin
                count_up(krl_pkg::TAB_CARD, it.name_key, it.ip, ok, c);
                if (!ok) begin lim = 1'b1; full = 1'b1; end
                else lim = c > lim_login;
            end
            krl_pkg::CMD_CANCEL_LOGIN: begin
                count_down(krl_pkg::TAB_LOGIN, it.name_key, it.ip, 1'b0);
                if (it.mac_present) count_down(krl_pkg::TAB_MAC, it.mac_key, '0, 1'b1);
            end
            krl_pkg::CMD_CANCEL_REG: begin
                if (!ip_bad) count_down(krl_pkg::TAB_REG, '0, it.ip, 1'b0);
            end
            krl_pkg::CMD_CANCEL_CARD:
                count_down(krl_pkg::TAB_CARD, it.name_key, it.ip, 1'b0);
            krl_pkg::CMD_LOGIN_OK: begin
                drop_slot(krl_pkg::TAB_LOGIN,
                          find_slot(krl_pkg::TAB_LOGIN, it.name_key, it.ip));
                if (it.mac_present) count_down(krl_pkg::TAB_MAC, it.mac_key, '0, 1'b1);
            end
            krl_pkg::CMD_REG_FAIL: begin
                i = find_slot(krl_pkg::TAB_REG, '0, it.ip);
                if (i >= 0) begin
                    if (slot_cnt[krl_pkg::TAB_REG][i] <= 1) drop_slot(krl_pkg::TAB_REG, i);
                    else slot_cnt[krl_pkg::TAB_REG][i]--;
                end
            end
            krl_pkg::CMD_CARD_OK:
                drop_slot(krl_pkg::TAB_CARD, find_slot(krl_pkg::TAB_CARD, it.name_key, it.ip));
            krl_pkg::CMD_HOUR: begin
                if (it.hour != cur_hour) begin
                    cur_hour = it.hour;
                    clear_tables();
                end
            end
            default: ;
        endcase
        r.limited          = lim;
        r.table_full       = full;
        r.login_entries    = krl_pkg::LIVE_BITS'(live_cnt[krl_pkg::TAB_LOGIN]);
        r.register_entries = krl_pkg::LIVE_BITS'(live_cnt[krl_pkg::TAB_REG]);
        r.mac_entries      = krl_pkg::LIVE_BITS'(live_cnt[krl_pkg::TAB_MAC]);
    endtask

    function automatic krl_pkg::t_in mk(logic [3:0] cmd, logic [31:0] ip, logic [63:0] n,
                                        logic [63:0] m, logic mp, logic [4:0] hr);
        krl_pkg::t_in it;
        it.command     = cmd;
        it.ip          = ip;
        it.name_key    = n;
        it.mac_key     = m;
        it.mac_present = mp;
        it.hour        = hr;
        return it;
    endfunction

    task automatic send_item(input krl_pkg::t_in it);
        int            g;
        krl_pkg::t_out p;
        g = tx_quiet ? 0 : ($urandom_range(0, 1) ? 0 : pick_gap());
        if (g > 0) begin
            in_valid <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_data  <= it;
        do @(posedge i_clk); while (!in_ready);
        predict_limit(it, p);
        pending_q.push_back(p);
    endtask

    // wait for every response, then let the block settle
    task automatic drain();
        in_valid <= 1'b0;
        while (pending_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic [1:0] idx, input logic [15:0] val);
        @(posedge i_clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge i_clk);
        cfg_we    <= 1'b0;
        case (idx)
            krl_pkg::CFG_MAX_REG:   lim_reg   = val;
            krl_pkg::CFG_MAX_LOGIN: lim_login = val;
            krl_pkg::CFG_MAX_MAC:   lim_mac   = val;
            default: ;
        endcase
    endtask

    task automatic set_limits(input logic [15:0] r, input logic [15:0] l,
                              input logic [15:0] m);
        cfg_write(krl_pkg::CFG_MAX_REG, r);
        cfg_write(krl_pkg::CFG_MAX_LOGIN, l);
        cfg_write(krl_pkg::CFG_MAX_MAC, m);
    endtask

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("MISMATCH %s: got %0d expected %0d (cycle %0d)", what, got, want, cycles);
        errors++;
    endtask

    // response checker and receiver stalls
    always @(posedge i_clk) begin
        krl_pkg::t_out want;
        if (out_valid && out_ready) begin
            if (pending_q.size() == 0) begin
                report_mismatch("unexpected transaction", out_data, 0);
            end else begin
                want = pending_q.pop_front();
                if (out_data.limited !== want.limited)
                    report_mismatch("limited", out_data.limited, want.limited);
                if (out_data.table_full !== want.table_full)
                    report_mismatch("table_full", out_data.table_full, want.table_full);
                if (out_data.login_entries !== want.login_entries)
                    report_mismatch("login_entries", out_data.login_entries,
                                    want.login_entries);
                if (out_data.register_entries !== want.register_entries)
                    report_mismatch("register_entries", out_data.register_entries,
                                    want.register_entries);
                if (out_data.mac_entries !== want.mac_entries)
                    report_mismatch("mac_entries", out_data.mac_entries, want.mac_entries);
            end
        end
        if (cycles % 500 == 0) rdy_calm = ($urandom_range(0, 3) == 0);
        if (hold_go != hold_seen) begin
            hold_seen = hold_go;
            hold_left = HOLD_LONG;
        end
        if (hold_left > 0) begin
            hold_left--;
            out_ready <= 1'b0;
        end else if (rdy_gap > 0) begin
            rdy_gap--;
            out_ready <= 1'b0;
        end else begin
            out_ready <= 1'b1;
            if (!rdy_calm && $urandom_range(0, 3) == 0) rdy_gap = pick_gap();
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > LIMIT_CYCLES) begin
            $display("Verification failed");
            $finish;
        end
    end

    task automatic test_directed();
        logic [31:0] ipa;
        logic [63:0] nk, mk_a;
        ipa  = 32'h0A00_0001;
        nk   = 64'hDEAD_BEEF_0123_4567;
        mk_a = 64'hFFFF_0000_FFFF_0000;
        send_item(mk(krl_pkg::CMD_CHK_REG, 32'h0, '0, '0, 1'b0, 5'd0));
        send_item(mk(krl_pkg::CMD_CHK_REG, 32'hFFFF_FFFF, '1, '1, 1'b1, 5'd0));
        send_item(mk(krl_pkg::CMD_CANCEL_REG, 32'h0, '0, '0, 1'b0, 5'd0));
        send_item(mk(krl_pkg::CMD_CHK_REG, ipa, '0, '0, 1'b0, 5'd0));
        send_item(mk(krl_pkg::CMD_CANCEL_REG, ipa, '0, '0, 1'b0, 5'd0));
        send_item(mk(krl_pkg::CMD_CANCEL_REG, ipa, '0, '0, 1'b0, 5'd0));   // stays at zero
        send_item(mk(krl_pkg::CMD_REG_FAIL, ipa, '0, '0, 1'b0, 5'd0));
        send_item(mk(krl_pkg::CMD_CHK_REG, ipa, '0, '0, 1'b0, 5'd0));
        send_item(mk(krl_pkg::CMD_CHK_REG, ipa, '0, '0, 1'b0, 5'd0));
        send_item(mk(krl_pkg::CMD_REG_FAIL, ipa, '0, '0, 1'b0, 5'd0));
        // login over its limit stops counting the MAC
        repeat (7) send_item(mk(krl_pkg::CMD_CHK_LOGIN, ipa, nk, mk_a, 1'b1, 5'd0));
        send_item(mk(krl_pkg::CMD_CANCEL_LOGIN, ipa, nk, mk_a, 1'b1, 5'd0));
        send_item(mk(krl_pkg::CMD_LOGIN_OK, ipa, nk, mk_a, 1'b1, 5'd0));
        send_item(mk(krl_pkg::CMD_CHK_CARD, 32'h0, nk, '0, 1'b0, 5'd0));
        send_item(mk(krl_pkg::CMD_CANCEL_CARD, 32'h0, nk, '0, 1'b0, 5'd0));
        send_item(mk(krl_pkg::CMD_CARD_OK, 32'h0, nk, '0, 1'b0, 5'd0));
        send_item(mk(4'd10, '1, '1, '1, 1'b1, 5'd31));
        send_item(mk(4'd15, '0, '0, '0, 1'b0, 5'd0));
        send_item(mk(krl_pkg::CMD_HOUR, '0, '0, '0, 1'b0, 5'd31));
        send_item(mk(krl_pkg::CMD_HOUR, '0, '0, '0, 1'b0, 5'd31));
        send_item(mk(krl_pkg::CMD_HOUR, '0, '0, '0, 1'b0, 5'd0));
        drain();
    endtask

    task automatic test_limit_extremes();
        logic [31:0] ipa;
        ipa = 32'hC0A8_0101;
        set_limits(16'd0, 16'd0, 16'd0);
        send_item(mk(krl_pkg::CMD_CHK_REG, ipa, '0, '0, 1'b0, 5'd0));
        send_item(mk(krl_pkg::CMD_CHK_LOGIN, ipa, 64'd7, 64'd9, 1'b1, 5'd0));
        send_item(mk(krl_pkg::CMD_CHK_CARD, ipa, 64'd7, '0, 1'b0, 5'd0));
        drain();
        set_limits(16'hFFFF, 16'hFFFF, 16'hFFFF);
        repeat (2) send_item(mk(krl_pkg::CMD_CHK_REG, ipa, '0, '0, 1'b0, 5'd0));
        repeat (2) send_item(mk(krl_pkg::CMD_CHK_LOGIN, ipa, 64'd8, 64'd9, 1'b1, 5'd0));
        send_item(mk(krl_pkg::CMD_CHK_CARD, ipa, 64'd7, '0, 1'b0, 5'd0));
        drain();
    endtask

    task automatic test_table_full();
        tx_quiet = 1'b1;
        send_item(mk(krl_pkg::CMD_HOUR, '0, '0, '0, 1'b0, 5'd1));
        for (int i = 1; i <= krl_pkg::TABLE_ENTRIES + 1; i++)
            send_item(mk(krl_pkg::CMD_CHK_REG, 32'(i), '0, '0, 1'b0, 5'd1));
        // last login finds the login table full, so the MAC step is skipped
        for (int i = 0; i <= krl_pkg::TABLE_ENTRIES; i++)
            send_item(mk(krl_pkg::CMD_CHK_LOGIN, 32'd5, 64'(i), 64'(i + 5000), 1'b1, 5'd1));
        send_item(mk(krl_pkg::CMD_LOGIN_OK, 32'd5, 64'd0, '0, 1'b0, 5'd1));
        // free login slot, but the MAC table is full
        send_item(mk(krl_pkg::CMD_CHK_LOGIN, 32'd5, 64'hFFFF_FFFF_0000_0001, 64'h1, 1'b1,
                     5'd1));
        send_item(mk(krl_pkg::CMD_HOUR, '0, '0, '0, 1'b0, 5'd2));
        tx_quiet = 1'b0;
        drain();
    endtask

    function automatic krl_pkg::t_in random_request();
        krl_pkg::t_in it;
        int           r;
        r = $urandom_range(0, 99);
        if (r < 20) it.command = krl_pkg::CMD_CHK_LOGIN;
        else if (r < 35) it.command = krl_pkg::CMD_CHK_REG;
        else if (r < 47) it.command = krl_pkg::CMD_CHK_CARD;
        else if (r < 55) it.command = krl_pkg::CMD_CANCEL_LOGIN;
        else if (r < 62) it.command = krl_pkg::CMD_CANCEL_REG;
        else if (r < 69) it.command = krl_pkg::CMD_CANCEL_CARD;
        else if (r < 77) it.command = krl_pkg::CMD_LOGIN_OK;
        else if (r < 85) it.command = krl_pkg::CMD_REG_FAIL;
        else if (r < 93) it.command = krl_pkg::CMD_CARD_OK;
        else if (r < 97) it.command = krl_pkg::CMD_HOUR;
        else it.command = 4'($urandom_range(10, 15));
        r = $urandom_range(0, 19);
        if (r == 0) it.ip = '0;
        else if (r == 1) it.ip = '1;
        else if (r == 2) it.ip = $urandom;
        else it.ip = ip_pool[$urandom_range(0, 7)];
        it.name_key = ($urandom_range(0, 15) == 0) ? {$urandom, $urandom}
                                                  : name_pool[$urandom_range(0, 5)];
        it.mac_key  = ($urandom_range(0, 15) == 0) ? {$urandom, $urandom}
                                                  : mac_pool[$urandom_range(0, 3)];
        it.mac_present = $urandom_range(0, 3) != 0;
        it.hour = ($urandom_range(0, 3) == 0) ? 5'($urandom_range(0, 31)) : cur_hour;
        return it;
    endfunction

    task automatic test_random();
        logic [15:0] lr, ll, lm;
        for (int i = 0; i < 8; i++) ip_pool[i] = $urandom;
        for (int i = 0; i < 6; i++) name_pool[i] = {$urandom, $urandom};
        for (int i = 0; i < 4; i++) mac_pool[i] = {$urandom, $urandom};
        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: begin lr = 16'd2; ll = 16'd1; lm = 16'd3; end
                1: begin lr = 16'd0; ll = 16'd0; lm = 16'd0; end
                2: begin lr = 16'hFFFF; ll = 16'hFFFF; lm = 16'hFFFF; end
                default: begin
                    lr = 16'($urandom_range(0, 8));
                    ll = 16'($urandom_range(0, 6));
                    lm = 16'($urandom_range(0, 10));
                end
            endcase
            set_limits(lr, ll, lm);
            if (ph == 3) hold_go <= hold_go + 1;   // receiver holds off, sender keeps going
            repeat (150) send_item(random_request());
            drain();
        end
    endtask

    initial begin
        i_rst_n   = 1'b0;
        in_valid  = 1'b0;
        in_data   = '0;
        out_ready = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        errors    = 0;
        cycles    = 0;
        tx_quiet  = 1'b0;
        hold_go   = 0;
        hold_seen = 0;
        hold_left = 0;
        rdy_gap   = 0;
        rdy_calm  = 1'b0;
        cur_hour  = '0;
        lim_reg   = krl_pkg::LIM_REG_DEFAULT;
        lim_login = krl_pkg::LIM_LOGIN_DEFAULT;
        lim_mac   = krl_pkg::LIM_MAC_DEFAULT;
        clear_tables();
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_limit_extremes();
        test_table_full();
        test_random();
        if (errors == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
